// ===== design/dtt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared types and constants for the DNS transaction id translator.
// ----------------------------------------------------------------------------
package dtt_pkg;

  // Number of slots in the remap table (256 to 65536)
  localparam int TABLE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  localparam logic [15:0] HEADER_BYTES = 16'd12;

  // Register indexes
  localparam logic CFG_RESPONSE_WINDOW = 1'b0;
  localparam logic CFG_REUSE_GUARD     = 1'b1;

  localparam logic [31:0] RESPONSE_WINDOW_RST = 32'd2000000;
  localparam logic [31:0] REUSE_GUARD_RST     = 32'd3000000;

  // Commands
  localparam logic CMD_QUERY    = 1'b0;
  localparam logic CMD_RESPONSE = 1'b1;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t STAT_FORWARDED = 3'd0;
  localparam status_t STAT_BUSY      = 3'd1;
  localparam status_t STAT_DELIVERED = 3'd2;
  localparam status_t STAT_STALE     = 3'd3;
  localparam status_t STAT_MISMATCH  = 3'd4;
  localparam status_t STAT_MALFORMED = 3'd5;

  typedef logic [ADDR_W-1:0] addr_t;

  // One table entry, held in a single memory word
  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] orig_id;
    logic [47:0] stamp;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_en;
    logic accept;
    logic exec_fire;
  } dtt_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
  } dtt_sts_t;

endpackage

// ===== design/dtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtt_ctrl
// Sequencer: table clear after reset, item accept, execute and result hand-off.
// ----------------------------------------------------------------------------
module dtt_ctrl import dtt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dtt_sts_t sts,
  output dtt_ctl_t ctl
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free      = !out_valid || !out_stall;
  assign in_stall      = (state != S_IDLE);
  assign ctl.clear_en  = (state == S_CLEAR);
  assign ctl.accept    = (state == S_IDLE) && in_valid;
  assign ctl.exec_fire = (state == S_EXEC) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (ctl.exec_fire) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_result_during_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid)
    else $error("result offered during table clear");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    ctl.accept |=> state == S_EXEC)
    else $error("accepted item did not enter execute");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    ctl.exec_fire |=> out_valid && state == S_IDLE)
    else $error("execute did not load a result");

endmodule

// ===== design/dtt_datapath.sv =====
// ----------------------------------------------------------------------------
// dtt_datapath
// Remap table memory, slot pointer, config registers, checks and result regs.
// ----------------------------------------------------------------------------
module dtt_datapath import dtt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dtt_ctl_t    ctl,
  output dtt_sts_t    sts,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        command,
  input  logic [15:0] packet_length,
  input  logic        qr_bit,
  input  logic [15:0] dns_id,
  input  logic [31:0] name_hash,
  input  logic [31:0] client_ip,
  input  logic [15:0] client_port,
  input  logic [47:0] now_us,
  output status_t     status,
  output logic [15:0] out_id,
  output logic [31:0] dest_ip,
  output logic [15:0] dest_port
);

  entry_t slot_mem [TABLE_DEPTH];

  logic [31:0] response_window_us;
  logic [31:0] reuse_guard_us;
  addr_t       next_slot;
  addr_t       clear_addr;

  // Item registers
  logic        it_cmd;
  logic        it_malformed;
  logic        it_out_range;
  addr_t       it_slot;
  logic [15:0] it_id;
  logic [31:0] it_hash;
  logic [31:0] it_ip;
  logic [15:0] it_port;
  logic [47:0] it_now;
  entry_t      rd_data;

  addr_t       rd_addr;
  logic        malformed_in;
  logic [48:0] guard_end;
  logic [48:0] window_end;
  logic        busy;
  logic        stale;
  logic        mismatch;
  logic        mem_we;
  addr_t       mem_waddr;
  entry_t      mem_wdata;
  status_t     status_next;
  logic        write_item;

  assign sts.clear_last = (clear_addr == addr_t'(TABLE_DEPTH - 1));

  assign malformed_in = (packet_length < HEADER_BYTES) || (qr_bit != command);
  assign rd_addr      = (command == CMD_RESPONSE) ? dns_id[ADDR_W-1:0] : next_slot;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      response_window_us <= RESPONSE_WINDOW_RST;
      reuse_guard_us     <= REUSE_GUARD_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_RESPONSE_WINDOW) response_window_us <= cfg_data;
      if (cfg_index == CFG_REUSE_GUARD)     reuse_guard_us     <= cfg_data;
    end
  end

  // Clear sweep and round-robin pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
      next_slot  <= '0;
    end else begin
      if (ctl.clear_en) begin
        clear_addr <= sts.clear_last ? '0 : clear_addr + addr_t'(1);
      end
      if (ctl.accept && command == CMD_QUERY && !malformed_in) begin
        next_slot <= (next_slot == addr_t'(TABLE_DEPTH - 1)) ? '0
                                                              : next_slot + addr_t'(1);
      end
    end
  end

  // Capture the item and read its slot
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      it_cmd       <= command;
      it_malformed <= malformed_in;
      it_out_range <= (32'(dns_id) >= 32'(TABLE_DEPTH));
      it_slot      <= rd_addr;
      it_id        <= dns_id;
      it_hash      <= name_hash;
      it_ip        <= client_ip;
      it_port      <= client_port;
      it_now       <= now_us;
      rd_data      <= slot_mem[rd_addr];
    end
  end

  // Checks against the stored entry
  assign guard_end  = {1'b0, rd_data.stamp} + 49'(reuse_guard_us);
  assign window_end = {1'b0, rd_data.stamp} + 49'(response_window_us);
  assign busy       = ({1'b0, it_now} < guard_end);
  assign stale      = it_out_range || ({1'b0, it_now} > window_end);
  assign mismatch   = (it_hash != rd_data.hash);

  always_comb begin
    write_item = 1'b0;
    if (it_malformed) begin
      status_next = STAT_MALFORMED;
    end else if (it_cmd == CMD_QUERY) begin
      status_next = busy ? STAT_BUSY : STAT_FORWARDED;
      write_item  = !busy;
    end else if (stale) begin
      status_next = STAT_STALE;
    end else if (mismatch) begin
      status_next = STAT_MISMATCH;
    end else begin
      status_next = STAT_DELIVERED;
      write_item  = 1'b1;
    end
  end

  // Write port: clear sweep, new query record, or release on delivery
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = it_slot;
    mem_wdata = rd_data;
    if (ctl.clear_en) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else if (ctl.exec_fire && write_item) begin
      mem_we = 1'b1;
      if (it_cmd == CMD_QUERY) begin
        mem_wdata.hash    = it_hash;
        mem_wdata.ip      = it_ip;
        mem_wdata.port    = it_port;
        mem_wdata.orig_id = it_id;
        mem_wdata.stamp   = it_now;
      end else begin
        mem_wdata.hash  = '0;
        mem_wdata.stamp = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (ctl.exec_fire) begin
      status    <= status_next;
      out_id    <= '0;
      dest_ip   <= '0;
      dest_port <= '0;
      if (status_next == STAT_FORWARDED) begin
        out_id <= 16'(it_slot);
      end else if (status_next == STAT_DELIVERED) begin
        out_id    <= rd_data.orig_id;
        dest_ip   <= rd_data.ip;
        dest_port <= rd_data.port;
      end
    end
  end

endmodule

// ===== design/dns_transaction_id_translator.sv =====
// ----------------------------------------------------------------------------
// dns_transaction_id_translator
// Transaction id remap table for a DNS proxy: queries get a slot id, responses
// are matched back to the client's id and address.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one DNS header per transfer.
//   Output channel (out_valid / out_stall) returns one result per transfer.
//   Config: pulse cfg_we with cfg_index / cfg_data while the block is idle;
//   index 0 is the response window, index 1 the reuse guard (microseconds).
// Timing:
//   An item is taken in the idle cycle, its slot is read from the table at
//   that edge, and the execute state then checks it, writes the slot back
//   and loads the output register, where out_valid rises; execute waits
//   while out_stall holds an earlier result. in_stall is high outside idle,
//   so a new item is taken only after the previous one has left execute.
// Reset:
//   rst (synchronous) restores the config registers and starts a clearing
//   pass over the table, one slot per cycle, over all TABLE_DEPTH (65536) slots.
//   in_stall stays high until it completes.
// Back-pressure:
//   While out_stall holds the result, one more item can be taken; it then
//   waits in execute until the output register frees up.
// ----------------------------------------------------------------------------
module dns_transaction_id_translator import dtt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] packet_length,
  input  logic        qr_bit,
  input  logic [15:0] dns_id,
  input  logic [31:0] name_hash,
  input  logic [31:0] client_ip,
  input  logic [15:0] client_port,
  input  logic [47:0] now_us,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] out_id,
  output logic [31:0] dest_ip,
  output logic [15:0] dest_port
);

  dtt_ctl_t ctl;
  dtt_sts_t sts;

  // Sequencer: clear pass, accept, execute, hand result to output
  dtt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Table, pointer, config registers and checks
  dtt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .command       (command),
    .packet_length (packet_length),
    .qr_bit        (qr_bit),
    .dns_id        (dns_id),
    .name_hash     (name_hash),
    .client_ip     (client_ip),
    .client_port   (client_port),
    .now_us        (now_us),
    .status        (status),
    .out_id        (out_id),
    .dest_ip       (dest_ip),
    .dest_port     (dest_port)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DNS transaction id translator testbench
// Feeds DNS header items through the remap table and compares every result
// field by field against an in-bench model of the slot table. The run covers
// a directed table and random query/response traffic under several register
// settings.
// ----------------------------------------------------------------------------
module testbench;
  import dtt_pkg::*;

  localparam int          MAX_IDLE     = 17;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          CYCLE_LIMIT  = 1_500_000;
  localparam logic [47:0] TIME_MAX     = '1;

  // One DNS header as seen by the input channel
  typedef struct packed {
    logic        command;
    logic [15:0] length;
    logic        qr;
    logic [15:0] id;
    logic [31:0] hash;
    logic [31:0] ip;
    logic [15:0] port;
    logic [47:0] now;
  } header_t;

  // One translation result as seen by the output channel
  typedef struct packed {
    status_t     status;
    logic [15:0] id;
    logic [31:0] ip;
    logic [15:0] port;
  } reply_t;

  // Row of the directed table; typed rows carry a hand-written result
  typedef struct {
    header_t hdr;
    bit      typed;
    reply_t  want;
  } vector_t;

  // Query that went out and may still get its response
  typedef struct packed {
    logic [15:0] slot;
    logic [31:0] hash;
  } open_query_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [15:0] packet_length = '0;
  logic        qr_bit = 1'b0;
  logic [15:0] dns_id = '0;
  logic [31:0] name_hash = '0;
  logic [31:0] client_ip = '0;
  logic [15:0] client_port = '0;
  logic [47:0] now_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [15:0] out_id;
  logic [31:0] dest_ip;
  logic [15:0] dest_port;

  // Mirror of the remap table and its registers
  bit [31:0]   map_hash   [TABLE_DEPTH];
  bit [31:0]   map_ip     [TABLE_DEPTH];
  bit [15:0]   map_port   [TABLE_DEPTH];
  bit [15:0]   map_client [TABLE_DEPTH];
  bit [47:0]   map_stamp  [TABLE_DEPTH];
  int unsigned map_next = 0;
  logic [31:0] window_reg = RESPONSE_WINDOW_RST;
  logic [31:0] guard_reg  = REUSE_GUARD_RST;

  reply_t      expected_replies[$];
  open_query_t open_queries[$];
  vector_t     directed[$];

  bit          idle_on = 1'b1;
  logic [47:0] now_t = '0;
  int          fail_count = 0;
  int          cycle_count = 0;
  int          stall_left = 0;

  dns_transaction_id_translator dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .packet_length (packet_length),
    .qr_bit        (qr_bit),
    .dns_id        (dns_id),
    .name_hash     (name_hash),
    .client_ip     (client_ip),
    .client_port   (client_port),
    .now_us        (now_us),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .out_id        (out_id),
    .dest_ip       (dest_ip),
    .dest_port     (dest_port)
  );

  always #5 clk = ~clk;

  // Translate one header against the mirror table and update it the way the
  // block must. Time sums are formed at 64 bits so they never wrap.
  function automatic reply_t translate_header(input header_t h);
    reply_t          r;
    int unsigned     s;
    longint unsigned limit;
    r = '0;
    if (h.length < HEADER_BYTES || h.qr != h.command) begin
      r.status = STAT_MALFORMED;
    end else if (h.command == CMD_QUERY) begin
      // the pointer advances whether or not the slot is free
      s = map_next;
      map_next = (s + 1) % TABLE_DEPTH;
      limit = 64'(map_stamp[s]) + 64'(guard_reg);
      if (64'(h.now) < limit) begin
        r.status = STAT_BUSY;
      end else begin
        map_hash[s]   = h.hash;
        map_ip[s]     = h.ip;
        map_port[s]   = h.port;
        map_client[s] = h.id;
        map_stamp[s]  = h.now;
        r.status = STAT_FORWARDED;
        r.id     = 16'(s);
      end
    end else if (int'(h.id) >= TABLE_DEPTH) begin
      r.status = STAT_STALE;
    end else begin
      limit = 64'(map_stamp[h.id]) + 64'(window_reg);
      if (64'(h.now) > limit) begin
        r.status = STAT_STALE;
      end else if (h.hash != map_hash[h.id]) begin
        r.status = STAT_MISMATCH;
      end else begin
        // only time and hash are cleared; the client address stays behind
        r.status = STAT_DELIVERED;
        r.id     = map_client[h.id];
        r.ip     = map_ip[h.id];
        r.port   = map_port[h.id];
        map_stamp[h.id] = '0;
        map_hash[h.id]  = '0;
      end
    end
    return r;
  endfunction

  function automatic header_t hdr(input logic cmd, input logic [15:0] len, input logic qr,
                                  input logic [15:0] id, input logic [31:0] hash,
                                  input logic [31:0] ip, input logic [15:0] port,
                                  input logic [47:0] now);
    header_t h;
    h.command = cmd;
    h.length  = len;
    h.qr      = qr;
    h.id      = id;
    h.hash    = hash;
    h.ip      = ip;
    h.port    = port;
    h.now     = now;
    return h;
  endfunction

  function automatic reply_t reply(input status_t st, input logic [15:0] id,
                                   input logic [31:0] ip, input logic [15:0] port);
    reply_t r;
    r.status = st;
    r.id     = id;
    r.ip     = ip;
    r.port   = port;
    return r;
  endfunction

  task automatic row(input header_t h, input bit typed, input reply_t want);
    vector_t v;
    v.hdr   = h;
    v.typed = typed;
    v.want  = want;
    directed.push_back(v);
  endtask

  // Present one header, record its expected result, and hold until the
  // transfer. Entered and left at a rising edge.
  task automatic issue(input header_t h, input bit typed, input reply_t want,
                       output reply_t pred);
    int unsigned gap;
    gap = idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command       <= h.command;
    packet_length <= h.length;
    qr_bit        <= h.qr;
    dns_id        <= h.id;
    name_hash     <= h.hash;
    client_ip     <= h.ip;
    client_port   <= h.port;
    now_us        <= h.now;
    in_valid      <= 1'b1;
    pred = translate_header(h);
    expected_replies.push_back(typed ? want : pred);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every result is back and the table is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; call only while idle
  task automatic configure(input logic [31:0] window, input logic [31:0] guard);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RESPONSE_WINDOW;
    cfg_data  <= window;
    @(posedge clk);
    cfg_index <= CFG_REUSE_GUARD;
    cfg_data  <= guard;
    @(posedge clk);
    cfg_we     <= 1'b0;
    window_reg = window;
    guard_reg  = guard;
  endtask

  // Random traffic: mostly queries and responses that answer an earlier
  // forwarded query, some with a wrong hash, plus a share of malformed noise.
  task automatic run_random(input int count, input int unsigned span);
    header_t     h;
    reply_t      pred;
    open_query_t oq;
    int unsigned pick;
    int unsigned k;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3, 0) != 0) now_t += $urandom_range(span, 0);
      h.length = ($urandom_range(7, 0) == 0) ? HEADER_BYTES : 16'($urandom_range(65535, 12));
      h.id     = 16'($urandom);
      h.hash   = $urandom;
      h.ip     = $urandom;
      h.port   = 16'($urandom);
      h.now    = now_t;
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
        h.command = 1'($urandom_range(1, 0));
        case ($urandom_range(2, 0))
          0: begin
            h.length = 16'($urandom_range(11, 0));
            h.qr     = h.command;
          end
          1: h.qr = ~h.command;
          default: begin
            h.qr     = 1'($urandom_range(1, 0));
            h.length = 16'($urandom);
            h.now    = 48'({$urandom, $urandom});
          end
        endcase
      end else if (pick < 55 || open_queries.size() == 0) begin
        h.command = CMD_QUERY;
        h.qr      = 1'b0;
      end else begin
        h.command = CMD_RESPONSE;
        h.qr      = 1'b1;
        if ($urandom_range(9, 0) != 0) begin
          k  = $urandom_range(open_queries.size() - 1, 0);
          oq = open_queries[k];
          open_queries.delete(k);
          h.id = oq.slot;
          if ($urandom_range(6, 0) != 0) h.hash = oq.hash;
        end
      end
      issue(h, 1'b0, '0, pred);
      if (h.command == CMD_QUERY && pred.status == STAT_FORWARDED)
        open_queries.push_back({pred.id, h.hash});
    end
  endtask

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("result with nothing expected: status %0d out_id %0h", status, out_id);
        fail_count++;
      end else begin
        want = expected_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (out_id !== want.id) begin
          $error("out_id: expected %0h, got %0h", want.id, out_id);
          fail_count++;
        end
        if (dest_ip !== want.ip) begin
          $error("dest_ip: expected %0h, got %0h", want.ip, dest_ip);
          fail_count++;
        end
        if (dest_port !== want.port) begin
          $error("dest_port: expected %0h, got %0h", want.port, dest_port);
          fail_count++;
        end
      end
    end
  end

  // Receiver back-pressure: after each result transfer, draw how long to
  // hold off the next one
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_stall) begin
      if (stall_left <= 1) out_stall <= 1'b0;
      stall_left = stall_left - 1;
    end else if (out_valid) begin
      stall_left = idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
      if (stall_left != 0) out_stall <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    reply_t  pred;

    // Directed table, run at the reset register values (window 2 s, guard 3 s).
    // Malformed: short packets and a QR bit that disagrees with the command.
    row(hdr(CMD_QUERY, 16'd11, 1'b0, 16'h1234, 32'h1, 32'h0a000001, 16'd5353, 48'd5000000),
        1'b1, reply(STAT_MALFORMED, '0, '0, '0));
    row(hdr(CMD_QUERY, 16'd0, 1'b0, 16'h0, 32'h0, 32'h0, 16'h0, 48'd0),
        1'b1, reply(STAT_MALFORMED, '0, '0, '0));
    row(hdr(CMD_QUERY, 16'd12, 1'b1, 16'h4321, 32'h2, 32'h0a000002, 16'd53, 48'd5000000),
        1'b1, reply(STAT_MALFORMED, '0, '0, '0));
    row(hdr(CMD_RESPONSE, 16'hFFFF, 1'b0, 16'h0, 32'h0, 32'h0, 16'h0, 48'd0),
        1'b1, reply(STAT_MALFORMED, '0, '0, '0));
    row(hdr(CMD_RESPONSE, 16'd11, 1'b1, 16'h0, 32'h0, 32'h0, 16'h0, 48'd0),
        1'b1, reply(STAT_MALFORMED, '0, '0, '0));
    // Empty slots hold time zero, so queries before the guard has run out
    // are refused; the pointer still moves on to slots 1 and 2
    row(hdr(CMD_QUERY, 16'd12, 1'b0, 16'h0001, 32'h3, 32'h0a000003, 16'd1000, 48'd0),
        1'b1, reply(STAT_BUSY, '0, '0, '0));
    row(hdr(CMD_QUERY, 16'd12, 1'b0, 16'h0002, 32'h4, 32'h0a000004, 16'd1001, 48'd2999999),
        1'b1, reply(STAT_BUSY, '0, '0, '0));
    row(hdr(CMD_QUERY, 16'hFFFF, 1'b0, 16'hFFFF, '1, '1, 16'hFFFF, 48'd3000000),
        1'b1, reply(STAT_FORWARDED, 16'd2, '0, '0));
    // Response on the last microsecond of the window
    row(hdr(CMD_RESPONSE, 16'd12, 1'b1, 16'd2, '1, 32'h0, 16'h0, 48'd5000000),
        1'b1, reply(STAT_DELIVERED, 16'hFFFF, '1, 16'hFFFF));
    // Cleared slot: time and hash are zero but the address is still there
    row(hdr(CMD_RESPONSE, 16'd12, 1'b1, 16'd2, 32'h0, 32'h0, 16'h0, 48'd2000000),
        1'b1, reply(STAT_DELIVERED, 16'hFFFF, '1, 16'hFFFF));
    row(hdr(CMD_RESPONSE, 16'd12, 1'b1, 16'd2, 32'h0, 32'h0, 16'h0, 48'd2000001),
        1'b1, reply(STAT_STALE, '0, '0, '0));
    // Never-written slot compares against hash zero
    row(hdr(CMD_RESPONSE, 16'd12, 1'b1, 16'hFFFF, 32'h5, 32'h0, 16'h0, 48'd0),
        1'b1, reply(STAT_MISMATCH, '0, '0, '0));
    row(hdr(CMD_RESPONSE, 16'd12, 1'b1, 16'hFFFF, 32'h0, 32'h0, 16'h0, 48'd0),
        1'b1, reply(STAT_DELIVERED, '0, '0, '0));
    // Time at its maximum: sums must not wrap
    row(hdr(CMD_QUERY, 16'd12, 1'b0, 16'h0, 32'hA5A55A5A, 32'h0, 16'h0, TIME_MAX),
        1'b1, reply(STAT_FORWARDED, 16'd3, '0, '0));
    row(hdr(CMD_RESPONSE, 16'd12, 1'b1, 16'd3, 32'hA5A55A5A, 32'h0, 16'h0, TIME_MAX),
        1'b1, reply(STAT_DELIVERED, '0, '0, '0));
    row(hdr(CMD_QUERY, 16'd512, 1'b0, 16'h8001, 32'h80000001, 32'hC0A80101, 16'd53, TIME_MAX),
        1'b0, '0);
    row(hdr(CMD_RESPONSE, 16'd512, 1'b1, 16'd4, 32'h00000001, 32'h0, 16'h0, TIME_MAX),
        1'b0, '0);
    row(hdr(CMD_RESPONSE, 16'd512, 1'b1, 16'd4, 32'h80000001, 32'h0, 16'h0, 48'd0),
        1'b0, '0);
    row(hdr(CMD_QUERY, 16'd1500, 1'b0, 16'h7FFE, 32'h5A5AA5A5, 32'h7F000001, 16'h8000, TIME_MAX),
        1'b0, '0);
    row(hdr(CMD_RESPONSE, 16'd1500, 1'b1, 16'd5, 32'h5A5AA5A5, 32'h0, 16'h0, TIME_MAX - 1),
        1'b0, '0);

    // Hold reset, then release it; the block then clears its table and
    // stalls the input until done
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    idle_on = 1'b1;
    foreach (directed[i]) issue(directed[i].hdr, directed[i].typed, directed[i].want, pred);
    settle();

    // Both registers at zero: only an unchanged clock gets a delivery
    configure('0, '0);
    now_t = 48'd1000;
    run_random(100, 2);
    settle();

    // Both at their maximum: fresh slots stay busy until time reaches the guard
    configure('1, '1);
    now_t = 48'h0000_FFFF_FE00;
    run_random(100, 64);
    settle();

    // Moderate settings, no idling on either side
    idle_on = 1'b0;
    configure(32'd1500, 32'd2500);
    run_random(120, 400);
    settle();

    idle_on = 1'b1;
    configure($urandom_range(3000, 0), $urandom_range(3000, 0));
    now_t += 48'h100_0000_0000;
    run_random(120, 700);
    settle();

    // Large guard: requeries of recent slots are refused, answers still land
    configure(32'd200000, '1);
    run_random(40, 500);
    settle();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
